[rtl/nfcs_pkg.sv]
// shared types, command constants and helpers for the nor flash command sequencer
`default_nettype none

package nfcs_pkg;

    localparam int SECTOR_COUNT_DEF      = 35;
    localparam int WORD_ADDRESS_BITS_DEF = 20;

    localparam int WORD_ADDR_W = 20;
    localparam int DATA_W      = 16;
    localparam int STEP_W      = 3;

    // host command selector
    typedef enum logic [1:0] {
        MODE_READ_ID = 2'd0,
        MODE_PROGRAM = 2'd1,
        MODE_ERASE   = 2'd2,
        MODE_POLL    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_REPORT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_BUSY     = 3'd1,
        ST_DONE     = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_IDLE     = 3'd4,
        ST_REJECTED = 3'd5
    } t_status;

    // bus-cycle sequence chosen for one command
    typedef enum logic [2:0] {
        JOB_REJECT  = 3'd0,
        JOB_IDLE    = 3'd1,
        JOB_READ_ID = 3'd2,
        JOB_PROGRAM = 3'd3,
        JOB_ERASE   = 3'd4,
        JOB_DONE    = 3'd5,
        JOB_TIMEOUT = 3'd6,
        JOB_BUSY    = 3'd7
    } t_job;

    typedef struct packed {
        t_kind                  kind;
        logic [WORD_ADDR_W-1:0] addr;
        logic [DATA_W-1:0]      data;
        t_status                status;
    } t_result;

    localparam logic [WORD_ADDR_W-1:0] ADDR_UNLOCK1 = 20'h00555;
    localparam logic [WORD_ADDR_W-1:0] ADDR_UNLOCK2 = 20'h002aa;
    localparam logic [WORD_ADDR_W-1:0] ADDR_ZERO    = 20'h00000;
    localparam logic [WORD_ADDR_W-1:0] ADDR_ONE     = 20'h00001;

    localparam logic [DATA_W-1:0] CMD_UNLOCK1     = 16'h00aa;
    localparam logic [DATA_W-1:0] CMD_UNLOCK2     = 16'h0055;
    localparam logic [DATA_W-1:0] CMD_AUTOSELECT  = 16'h0090;
    localparam logic [DATA_W-1:0] CMD_RESET       = 16'h00f0;
    localparam logic [DATA_W-1:0] CMD_ERASE_SETUP = 16'h0080;
    localparam logic [DATA_W-1:0] CMD_SECTOR_ERS  = 16'h0030;
    localparam logic [DATA_W-1:0] CMD_CHIP_ERS    = 16'h0010;
    localparam logic [DATA_W-1:0] CMD_PROGRAM     = 16'h00a0;

    localparam int DQ6 = 6;
    localparam int DQ5 = 5;

    // boot-sector layout: small sectors at the bottom, then 32k-word sectors
    function automatic logic [WORD_ADDR_W-1:0] sector_word_addr(input logic [5:0] sec);
        logic [5:0] rel;
        rel = sec - 6'd3;
        case (sec)
            6'd0:    sector_word_addr = 20'h00000;
            6'd1:    sector_word_addr = 20'h02000;
            6'd2:    sector_word_addr = 20'h03000;
            6'd3:    sector_word_addr = 20'h04000;
            default: sector_word_addr = {rel[4:0], 15'd0};
        endcase
    endfunction

endpackage

`default_nettype wire

[rtl/nfcs_step.sv]
// result generator: one bus cycle or report for a given sequence and step
`default_nettype none

module nfcs_step
    import nfcs_pkg::*;
(
    input  var t_job                   i_job,
    input  var logic [STEP_W-1:0]      i_step,
    input  var logic [WORD_ADDR_W-1:0] i_addr,
    input  var logic [DATA_W-1:0]      i_data,
    output t_result                    o_res,
    output logic                       o_last
);

    function automatic t_result wr(input logic [WORD_ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
        t_result r;
        r.kind   = KIND_WRITE;
        r.addr   = a;
        r.data   = d;
        r.status = ST_NONE;
        return r;
    endfunction

    function automatic t_result rd(input logic [WORD_ADDR_W-1:0] a);
        t_result r;
        r.kind   = KIND_READ;
        r.addr   = a;
        r.data   = '0;
        r.status = ST_NONE;
        return r;
    endfunction

    function automatic t_result rpt(input t_status s);
        t_result r;
        r.kind   = KIND_REPORT;
        r.addr   = '0;
        r.data   = '0;
        r.status = s;
        return r;
    endfunction

    always_comb begin
        o_res  = rpt(ST_NONE);
        o_last = 1'b1;
        unique case (i_job)
            JOB_REJECT: o_res = rpt(ST_REJECTED);
            JOB_IDLE:   o_res = rpt(ST_IDLE);
            JOB_DONE:   o_res = rpt(ST_DONE);
            JOB_BUSY:   o_res = rpt(ST_BUSY);
            JOB_TIMEOUT: begin
                if (i_step == 3'd0) begin
                    o_res  = wr(ADDR_ZERO, CMD_RESET);
                    o_last = 1'b0;
                end else begin
                    o_res = rpt(ST_TIMEOUT);
                end
            end
            JOB_READ_ID: begin
                o_last = (i_step == 3'd5);
                case (i_step)
                    3'd0:    o_res = wr(ADDR_UNLOCK1, CMD_UNLOCK1);
                    3'd1:    o_res = wr(ADDR_UNLOCK2, CMD_UNLOCK2);
                    3'd2:    o_res = wr(ADDR_UNLOCK1, CMD_AUTOSELECT);
                    3'd3:    o_res = rd(ADDR_ZERO);
                    3'd4:    o_res = rd(ADDR_ONE);
                    default: o_res = wr(ADDR_ZERO, CMD_RESET);
                endcase
            end
            JOB_PROGRAM: begin
                o_last = (i_step == 3'd3);
                case (i_step)
                    3'd0:    o_res = wr(ADDR_UNLOCK1, CMD_UNLOCK1);
                    3'd1:    o_res = wr(ADDR_UNLOCK2, CMD_UNLOCK2);
                    3'd2:    o_res = wr(ADDR_UNLOCK1, CMD_PROGRAM);
                    default: o_res = wr(i_addr, i_data);
                endcase
            end
            JOB_ERASE: begin
                o_last = (i_step == 3'd5);
                case (i_step)
                    3'd0:    o_res = wr(ADDR_UNLOCK1, CMD_UNLOCK1);
                    3'd1:    o_res = wr(ADDR_UNLOCK2, CMD_UNLOCK2);
                    3'd2:    o_res = wr(ADDR_UNLOCK1, CMD_ERASE_SETUP);
                    3'd3:    o_res = wr(ADDR_UNLOCK1, CMD_UNLOCK1);
                    3'd4:    o_res = wr(ADDR_UNLOCK2, CMD_UNLOCK2);
                    default: o_res = wr(i_addr, i_data);
                endcase
            end
            default: o_res = rpt(ST_NONE);
        endcase
    end

endmodule

`default_nettype wire

[rtl/nor_flash_command_sequencer.sv]
// nor flash command sequencer top level: command decode, step counter, output register
//
// host commands come in on the slave stream (tuser = mode, tdata = fields), one
// transaction per command. each command expands into one to six results on the
// master stream: flash bus writes, bus read requests or a status report, with
// tlast on the final result of the command.
// a command is decoded in the cycle it is accepted; busy and timeout state update
// at that edge. the step counter then emits one result per cycle into the output
// register while the receiver keeps up; the decoded command is held in the job
// registers and its first result is then loaded into the output register.
// throughput: one result per cycle while the receiver keeps up; a command holds the
// sequencer until all its results are issued (read id and erase 6, program 4, timeout 2, reports 1).
// the next command is accepted in the cycle the last result of the current one
// moves into the output register, so commands run back to back.
// when the receiver stalls, the output register holds its result and the step
// counter waits; input tready drops until the last result can be loaded.
// synchronous active-low reset clears valid flags, step counter and the
// pending-operation and timeout flags; no result is pending after reset.
`default_nettype none

module nor_flash_command_sequencer
    import nfcs_pkg::*;
#(
    parameter int SECTOR_COUNT      = SECTOR_COUNT_DEF,
    parameter int WORD_ADDRESS_BITS = WORD_ADDRESS_BITS_DEF
)(
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var logic        i_s_tvalid,
    output logic            o_s_tready,
    // byte_address[20:0], write_data[36:21], sector[42:37], first_status[58:43],
    // second_status[74:59], zero fill [79:75]
    input  var logic [79:0] i_s_tdata,
    // mode[1:0]
    input  var logic [1:0]  i_s_tuser,
    output logic            o_m_tvalid,
    input  var logic        i_m_tready,
    // word_address[19:0], bus_data[35:20], status[38:36], zero fill [39]
    output logic [39:0]     o_m_tdata,
    // cycle_kind[1:0]
    output logic [1:0]      o_m_tuser,
    output logic            o_m_tlast
);

    localparam int ADDR_BITS = (WORD_ADDRESS_BITS < WORD_ADDR_W) ? WORD_ADDRESS_BITS
                                                                 : WORD_ADDR_W;
    localparam logic [WORD_ADDR_W-1:0] ADDR_MASK =
        WORD_ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [6:0] SECTOR_LIMIT = 7'(SECTOR_COUNT);

    t_mode               s_mode;
    logic [20:0]         s_byte_addr;
    logic [DATA_W-1:0]   s_wdata;
    logic [5:0]          s_sector;
    logic [DATA_W-1:0]   s_status1;
    logic [DATA_W-1:0]   s_status2;

    assign s_mode      = t_mode'(i_s_tuser);
    assign s_byte_addr = i_s_tdata[20:0];
    assign s_wdata     = i_s_tdata[36:21];
    assign s_sector    = i_s_tdata[42:37];
    assign s_status1   = i_s_tdata[58:43];
    assign s_status2   = i_s_tdata[74:59];

    logic                   r_job_valid;
    t_job                   r_job, n_job;
    logic [STEP_W-1:0]      r_step;
    logic [WORD_ADDR_W-1:0] r_job_addr, n_job_addr;
    logic [DATA_W-1:0]      r_job_data, n_job_data;
    logic                   r_busy, n_busy;
    logic                   r_timeout, n_timeout;
    logic                   r_out_valid;
    t_result                r_out;
    logic                   r_out_last;

    t_result                step_res;
    logic                   step_last;
    logic                   out_load;
    logic                   s_acc;
    logic                   toggled;
    logic                   unused_fill;

    assign unused_fill = ^i_s_tdata[79:75];

    nfcs_step u_step (
        .i_job  (r_job),
        .i_step (r_step),
        .i_addr (r_job_addr),
        .i_data (r_job_data),
        .o_res  (step_res),
        .o_last (step_last)
    );

    assign out_load   = r_job_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_job_valid || (step_last && out_load);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign toggled    = s_status1[DQ6] ^ s_status2[DQ6];

    // command decode and pending-operation state
    always_comb begin
        n_job      = JOB_REJECT;
        n_job_addr = ADDR_ZERO;
        n_job_data = '0;
        n_busy     = r_busy;
        n_timeout  = r_timeout;
        if (s_mode != MODE_POLL && r_busy) begin
            n_job = JOB_REJECT;
        end else begin
            unique case (s_mode)
                MODE_READ_ID: n_job = JOB_READ_ID;
                MODE_PROGRAM: begin
                    n_job      = JOB_PROGRAM;
                    n_job_addr = s_byte_addr[20:1];
                    n_job_data = s_wdata;
                    n_busy     = 1'b1;
                    n_timeout  = 1'b0;
                end
                MODE_ERASE: begin
                    n_job     = JOB_ERASE;
                    n_busy    = 1'b1;
                    n_timeout = 1'b0;
                    if ({1'b0, s_sector} < SECTOR_LIMIT) begin
                        n_job_addr = sector_word_addr(s_sector);
                        n_job_data = CMD_SECTOR_ERS;
                    end else begin
                        n_job_addr = ADDR_UNLOCK1;
                        n_job_data = CMD_CHIP_ERS;
                    end
                end
                MODE_POLL: begin
                    if (!r_busy) begin
                        n_job = JOB_IDLE;
                    end else if (!toggled) begin
                        n_job     = JOB_DONE;
                        n_busy    = 1'b0;
                        n_timeout = 1'b0;
                    end else if (r_timeout) begin
                        n_job     = JOB_TIMEOUT;
                        n_busy    = 1'b0;
                        n_timeout = 1'b0;
                    end else begin
                        n_job = JOB_BUSY;
                        if (s_status2[DQ5]) begin
                            n_timeout = 1'b1;
                        end
                    end
                end
                default: n_job = JOB_REJECT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_step      <= '0;
            r_busy      <= 1'b0;
            r_timeout   <= 1'b0;
        end else if (s_acc) begin
            r_job_valid <= 1'b1;
            r_step      <= '0;
            r_busy      <= n_busy;
            r_timeout   <= n_timeout;
        end else if (out_load) begin
            if (step_last) begin
                r_job_valid <= 1'b0;
            end else begin
                r_step <= r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_job      <= n_job;
            r_job_addr <= n_job_addr;
            r_job_data <= n_job_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out      <= step_res;
            r_out_last <= step_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {unused_fill & 1'b0, r_out.status, r_out.data, r_out.addr & ADDR_MASK};
    assign o_m_tlast  = r_out_last;

    // a timeout sighting only exists while an operation is pending
    a_timeout_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timeout |-> r_busy)
        else $error("timeout flag set without a pending operation");

    // program or erase accepted while idle leaves an operation pending
    a_program_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !r_busy && (s_mode == MODE_PROGRAM || s_mode == MODE_ERASE))
        |=> r_busy)
        else $error("program or erase did not mark the operation pending");

    // a status report always closes its command
    a_report_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_REPORT) |-> o_m_tlast)
        else $error("status report without tlast");

    // the step counter never runs past the longest sequence
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_step <= 3'd5))
        else $error("step counter out of range");

endmodule

`default_nettype wire
